### src/swmm_pkg.sv
package swmm_pkg;

  localparam int SLOT_W     = 10;
  localparam int WINDOW_MAX = 1 << SLOT_W;
  localparam int CNT_W      = SLOT_W + 1;
  localparam int NODE_W     = SLOT_W + 1;
  localparam int NODE_COUNT = 2 * WINDOW_MAX;
  localparam int LEVELS     = SLOT_W;
  localparam int LEVEL_W    = $clog2(LEVELS + 1);
  localparam int SAMPLE_W   = 32;
  localparam int CFG_W      = 11;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [SLOT_W-1:0]          slot_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [NODE_W-1:0]          node_addr_t;
  typedef logic [CFG_W-1:0]           cfg_t;

  localparam sample_t SAMPLE_MAX = sample_t'({1'b0, {(SAMPLE_W-1){1'b1}}});
  localparam sample_t SAMPLE_MIN = ~SAMPLE_MAX;

  typedef struct packed {
    sample_t sample;
    logic    restart;
  } in_t;

  typedef struct packed {
    sample_t window_min;
    sample_t window_max;
  } out_t;

  typedef struct packed {
    sample_t min_v;
    sample_t max_v;
  } node_t;

  localparam node_t NODE_NEUTRAL = '{min_v: SAMPLE_MAX, max_v: SAMPLE_MIN};

  // request to start a leaf-to-root walk
  typedef struct packed {
    logic    start;
    slot_t   slot;
    cnt_t    fill;
    sample_t value;
  } walk_req_t;

  typedef struct packed {
    logic  done;
    node_t root;
  } walk_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_HOLD
  } state_t;

endpackage

### src/swmm_ram.sv
module swmm_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/swmm_walk.sv
module swmm_walk (
  input  logic                clk,
  input  logic                rst,
  input  swmm_pkg::walk_req_t req,
  output swmm_pkg::walk_stat_t stat
);

  logic                          active;
  logic [swmm_pkg::LEVEL_W-1:0]  level;
  swmm_pkg::slot_t               slot;
  swmm_pkg::cnt_t                fill;
  swmm_pkg::node_t               cur;

  logic                          we;
  swmm_pkg::node_addr_t          waddr;
  swmm_pkg::node_t               wdata;
  logic                          re;
  swmm_pkg::node_addr_t          raddr;
  swmm_pkg::node_t               rdata;

  swmm_pkg::node_addr_t          sib_lowest;
  logic                          sib_valid;
  swmm_pkg::node_t               sib;
  swmm_pkg::node_t               merged;
  swmm_pkg::node_addr_t          parent;
  logic                          last;

  swmm_ram #(
    .DEPTH(swmm_pkg::NODE_COUNT),
    .WIDTH($bits(swmm_pkg::node_t))
  ) u_tree (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Leaves at or above the fill count were not written since the last clear,
  // and a subtree whose first leaf is among them is read as neutral extremes.
  assign sib_lowest = ((swmm_pkg::node_addr_t'({1'b0, slot}) >> level)
                       ^ swmm_pkg::node_addr_t'(1)) << level;
  assign sib_valid  = sib_lowest < fill;
  assign sib        = sib_valid ? rdata : swmm_pkg::NODE_NEUTRAL;

  always_comb begin
    merged.min_v = (cur.min_v < sib.min_v) ? cur.min_v : sib.min_v;
    merged.max_v = (cur.max_v > sib.max_v) ? cur.max_v : sib.max_v;
  end

  assign parent = swmm_pkg::node_addr_t'({1'b1, slot})
                  >> (swmm_pkg::LEVEL_W'(level + 1'b1));
  assign last   = level == swmm_pkg::LEVEL_W'(swmm_pkg::LEVELS - 1);

  // Sibling addresses are fixed by the slot, so a read goes out at each step but the last;
  // a sibling is never on the path being written.
  always_comb begin
    we    = 1'b0;
    waddr = parent;
    wdata = merged;
    re    = 1'b0;
    raddr = parent ^ swmm_pkg::node_addr_t'(1);
    if (req.start) begin
      we    = 1'b1;
      waddr = swmm_pkg::node_addr_t'({1'b1, req.slot});
      wdata = '{min_v: req.value, max_v: req.value};
      re    = 1'b1;
      raddr = swmm_pkg::node_addr_t'({1'b1, req.slot}) ^ swmm_pkg::node_addr_t'(1);
    end else if (active) begin
      we = 1'b1;
      re = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      level  <= '0;
    end else if (req.start) begin
      active <= 1'b1;
      level  <= '0;
    end else if (active) begin
      active <= !last;
      level  <= swmm_pkg::LEVEL_W'(level + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      slot <= req.slot;
      fill <= req.fill;
      cur  <= '{min_v: req.value, max_v: req.value};
    end else if (active) begin
      cur  <= merged;
    end
  end

  assign stat.done = active && last;
  assign stat.root = merged;

endmodule

### src/sliding_window_min_max.sv
// Sliding window minimum / maximum over a stream of signed samples.
//
// Channels: in (valid/ready, in_t: sample, restart), out (valid/ready, out_t:
// window_min, window_max), cfg (valid/ready, window_size). A cfg write also
// empties the window. Write cfg only while no transaction is in flight.
//
// Each sample is walked from leaf to root: the leaf is stored and its sibling
// fetched, then each tree level (10) merges the sibling read from the node RAM,
// whose registered read and single read port pace the walk. A new sample is
// taken once the FSM is back in ST_IDLE, via ST_HOLD if the result must wait.
// The walk's result goes to the output register, once the window holds
// window_size samples; before that a sample gives no result.
//
// If the receiver stalls, the next sample is still accepted; its result
// waits in a hold register and input stalls only until the output frees.
// Reset: window_size = 1, window empty. Tree RAM needs no clearing pass;
// nodes past the fill count read as neutral extremes.
module sliding_window_min_max (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  swmm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output swmm_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  swmm_pkg::cfg_t cfg_data
);

  swmm_pkg::state_t     state, state_next;
  swmm_pkg::cfg_t       window_size;
  swmm_pkg::slot_t      write_slot;
  swmm_pkg::cnt_t       fill_count;
  logic                 emit;
  swmm_pkg::node_t      pend;

  swmm_pkg::cnt_t       k;
  logic                 in_acc;
  logic                 cfg_acc;
  swmm_pkg::slot_t      slot_pre;
  swmm_pkg::cnt_t       fill_pre;
  swmm_pkg::cnt_t       slot_inc;
  swmm_pkg::slot_t      slot_next;
  swmm_pkg::cnt_t       fill_next;
  logic                 emit_next;

  logic                 out_free;
  logic                 out_load;
  logic                 pend_load;
  swmm_pkg::node_t      out_src;

  swmm_pkg::walk_req_t  req;
  swmm_pkg::walk_stat_t stat;

  swmm_walk u_walk (
    .clk (clk),
    .rst (rst),
    .req (req),
    .stat(stat)
  );

  always_comb begin
    if (window_size == '0) begin
      k = swmm_pkg::cnt_t'(1);
    end else if (window_size > swmm_pkg::CFG_W'(swmm_pkg::WINDOW_MAX)) begin
      k = swmm_pkg::cnt_t'(swmm_pkg::WINDOW_MAX);
    end else begin
      k = swmm_pkg::cnt_t'(window_size);
    end
  end

  // cfg wins a same-cycle collision with input
  assign cfg_ready = state == swmm_pkg::ST_IDLE;
  assign in_ready  = (state == swmm_pkg::ST_IDLE) && !cfg_valid;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  assign slot_pre  = in_data.restart ? '0 : write_slot;
  assign fill_pre  = in_data.restart ? '0 : fill_count;
  assign slot_inc  = swmm_pkg::cnt_t'({1'b0, slot_pre}) + 1'b1;
  assign slot_next = (slot_inc >= k) ? '0 : slot_inc[swmm_pkg::SLOT_W-1:0];
  assign fill_next = (fill_pre < k) ? swmm_pkg::cnt_t'(fill_pre + 1'b1) : fill_pre;
  assign emit_next = fill_next >= k;

  assign req.start = in_acc;
  assign req.slot  = slot_pre;
  assign req.fill  = fill_pre;
  assign req.value = in_data.sample;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swmm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    pend_load  = 1'b0;
    out_src    = stat.root;
    case (state)
      swmm_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = swmm_pkg::ST_WALK;
        end
      end
      swmm_pkg::ST_WALK: begin
        if (stat.done) begin
          if (!emit) begin
            state_next = swmm_pkg::ST_IDLE;
          end else if (out_free) begin
            out_load   = 1'b1;
            state_next = swmm_pkg::ST_IDLE;
          end else begin
            pend_load  = 1'b1;
            state_next = swmm_pkg::ST_HOLD;
          end
        end
      end
      swmm_pkg::ST_HOLD: begin
        out_src = pend;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = swmm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swmm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swmm_pkg::cfg_t'(1);
      write_slot  <= '0;
      fill_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_acc) begin
        window_size <= cfg_data;
        write_slot  <= '0;
        fill_count  <= '0;
      end else if (in_acc) begin
        write_slot  <= slot_next;
        fill_count  <= fill_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      emit <= emit_next;
    end
    if (pend_load) begin
      pend <= stat.root;
    end
    if (out_load) begin
      out_data.window_min <= out_src.min_v;
      out_data.window_max <= out_src.max_v;
    end
  end

endmodule

### src/swmm_checker.sv
module swmm_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input swmm_pkg::out_t out_data,
  input logic           cfg_valid,
  input logic           cfg_ready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // one sample at a time: busy right after a transaction
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && !cfg_ready)
    else $error("input taken while a walk is in progress");

  a_no_collision: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_ready && cfg_valid && cfg_ready))
    else $error("input and cfg transactions in the same cycle");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind sliding_window_min_max swmm_checker u_swmm_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data),
  .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready)
);

### test/window_extremes_checker.sv
`timescale 1ns / 1ps

module window_extremes_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  swmm_pkg::in_t     in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  swmm_pkg::out_t    out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  swmm_pkg::cfg_t    cfg_data,
  input  logic              wrap_up,
  output int                errors,
  output int                pending
);

  swmm_pkg::cfg_t    window_reg;
  swmm_pkg::slot_t   next_slot;
  swmm_pkg::cnt_t    filled;
  swmm_pkg::sample_t slots [0:swmm_pkg::WINDOW_MAX-1];
  swmm_pkg::out_t    extremes_due [$];

  // zero acts as one, anything past the store size is clipped
  function automatic int unsigned span(swmm_pkg::cfg_t w);
    if (w == '0) return 1;
    if (w > swmm_pkg::CFG_W'(swmm_pkg::WINDOW_MAX)) return swmm_pkg::WINDOW_MAX;
    return 32'(w);
  endfunction

  task automatic empty_window();
    next_slot = '0;
    filled    = '0;
  endtask

  task automatic note_mismatch(string what, swmm_pkg::sample_t want,
                               swmm_pkg::sample_t got);
    errors++;
    if (errors <= 10)
      $display("%0t: %s mismatch, expected %0d (%h) got %0d (%h)",
               $realtime, what, want, want, got, got);
  endtask

  task automatic predict_extremes(swmm_pkg::in_t item);
    int unsigned    k;
    swmm_pkg::out_t res;
    k = span(window_reg);
    if (item.restart) empty_window();
    slots[next_slot] = item.sample;
    if (int'(next_slot) + 1 >= k) next_slot = '0;
    else next_slot = next_slot + 1'b1;
    if (filled < k) filled = filled + 1'b1;
    if (filled == k) begin
      res.window_min = swmm_pkg::SAMPLE_MAX;
      res.window_max = swmm_pkg::SAMPLE_MIN;
      for (int i = 0; i < k; i++) begin
        if (slots[i] < res.window_min) res.window_min = slots[i];
        if (slots[i] > res.window_max) res.window_max = slots[i];
      end
      extremes_due.push_back(res);
    end
  endtask

  task automatic check_result(swmm_pkg::out_t got);
    swmm_pkg::out_t want;
    if (extremes_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: result with none expected, min %0d max %0d",
                 $realtime, got.window_min, got.window_max);
    end else begin
      want = extremes_due.pop_front();
      if (got.window_min !== want.window_min)
        note_mismatch("window_min", want.window_min, got.window_min);
      if (got.window_max !== want.window_max)
        note_mismatch("window_max", want.window_max, got.window_max);
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  // result is checked before this edge's input so a fresh expectation
  // can never absorb an unexpected result
  always @(posedge clk) begin
    if (rst) begin
      window_reg = swmm_pkg::cfg_t'(1);
      empty_window();
      extremes_due.delete();
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (cfg_valid && cfg_ready) begin
        window_reg = cfg_data;
        empty_window();
      end
      if (in_valid && in_ready) predict_extremes(in_data);
      if (wrap_up && extremes_due.size() > 0) begin
        errors += extremes_due.size();
        $display("%0t: %0d expected results never arrived",
                 $realtime, extremes_due.size());
        extremes_due.delete();
      end
    end
    pending = extremes_due.size();
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_ready;
  swmm_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  swmm_pkg::out_t out_data;
  logic           cfg_valid;
  logic           cfg_ready;
  swmm_pkg::cfg_t cfg_data;
  logic           wrap_up;
  int             errors;
  int             pending;

  bit   quiet;     // no idling on either side
  bit   hold_req;  // asks the receiver for one long hold-off

  sliding_window_min_max dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  window_extremes_checker chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .wrap_up   (wrap_up),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("sliding_window_min_max test failed");
    $finish;
  end

  function automatic swmm_pkg::sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return swmm_pkg::SAMPLE_MAX;
      1: return swmm_pkg::SAMPLE_MIN;
      2: return swmm_pkg::sample_t'($signed($urandom_range(0, 8)) - 4);
      default: return swmm_pkg::sample_t'($urandom);
    endcase
  endfunction

  task automatic send_sample(swmm_pkg::sample_t s, logic r);
    int unsigned   gap;
    swmm_pkg::in_t item;
    gap = quiet ? 0 : $urandom_range(0, 7);
    item.sample  = s;
    item.restart = r;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // waits for every result plus the walk of a last result-less sample
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_window(swmm_pkg::cfg_t w);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random hold-off before each transaction, one long stall on request
  initial begin
    int unsigned n;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = 300;
      end else begin
        n = quiet ? 0 : $urandom_range(0, 7);
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    int          phase_windows [0:9];
    int unsigned odds;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    wrap_up   = 1'b0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    phase_windows = '{2, 1, 5, 0, 8, 3, 16, 40, 4, 1};
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // window of one straight out of reset
    send_sample(swmm_pkg::SAMPLE_MAX, 1'b0);
    send_sample(swmm_pkg::SAMPLE_MIN, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b1);

    // zero window behaves as one
    write_window(swmm_pkg::cfg_t'(0));
    send_sample(123, 1'b0);
    send_sample(swmm_pkg::SAMPLE_MIN, 1'b1);

    // a register write empties the window even at the same size
    write_window(swmm_pkg::cfg_t'(3));
    send_sample(swmm_pkg::SAMPLE_MAX, 1'b0);
    send_sample(swmm_pkg::SAMPLE_MIN, 1'b0);
    write_window(swmm_pkg::cfg_t'(3));
    send_sample(5, 1'b0);
    send_sample(-7, 1'b0);
    send_sample(9, 1'b0);
    send_sample(swmm_pkg::SAMPLE_MAX, 1'b0);
    send_sample(1, 1'b1);
    send_sample(2, 1'b0);
    send_sample(3, 1'b0);

    // oversized window, never fills here
    write_window(swmm_pkg::cfg_t'(2047));
    send_sample(10, 1'b0);
    send_sample(-10, 1'b0);

    for (int p = 0; p < 10; p++) begin
      write_window(swmm_pkg::cfg_t'(phase_windows[p]));
      quiet = (p == 5);
      odds  = (phase_windows[p] > 8) ? 200 : 20;
      for (int i = 0; i < 48; i++) begin
        if (p == 1 && i == 20) hold_req = 1'b1;
        send_sample(pick_sample(), $urandom_range(0, odds - 1) == 0);
      end
    end
    quiet = 1'b0;

    // wider window, reaches the upper tree levels
    write_window(swmm_pkg::cfg_t'(200));
    for (int i = 0; i < 210; i++) send_sample(pick_sample(), 1'b0);

    settle();
    repeat (30) @(negedge clk);
    wrap_up <= 1'b1;
    @(negedge clk);
    wrap_up <= 1'b0;
    @(negedge clk);
    if (errors == 0)
      $display("sliding_window_min_max test passed");
    else
      $display("sliding_window_min_max test failed");
    $finish;
  end

endmodule
